// ===== src/catmull_rom_point_eval_assert.svh =====
// Assertion macros, clocked on aclk, disabled while aresetn is low.
`ifndef CATMULL_ROM_POINT_EVAL_ASSERT_SVH
`define CATMULL_ROM_POINT_EVAL_ASSERT_SVH

// same-cycle implication
`define CRPE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("catmull_rom_point_eval: assertion failed");

// next-cycle implication
`define CRPE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("catmull_rom_point_eval: assertion failed");

`endif

// ===== src/crpe_pkg.sv =====
package crpe_pkg;

    localparam int COORD_W = 12;
    localparam int POINT_W = 2 * COORD_W;
    localparam int T_W     = 17;
    localparam int OUT_W   = 22;
    localparam int MUL_A_W = 35;
    localparam int MUL_P_W = 53;
    localparam int H_W     = 44;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_EVAL   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TOO_FEW = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [T_W-1:0]     ONE_Q16    = 17'h10000;
    localparam logic [MUL_P_W-1:0] ROUND_HALF = 53'd1 << 40;
    localparam logic [OUT_W-1:0]   OUT_MAX    = 22'h1FFFFF;
    localparam logic [OUT_W-1:0]   OUT_MIN    = 22'h200000;

endpackage

// ===== src/catmull_rom_point_eval.sv =====
// Sequence: clear and append run an execute state and a done state; evaluate adds
// a segment multiply, 4 reads and 2 x 5 Horner steps before done, which waits for a free output.
// A new request is taken only in idle, once the last result is in the output register;
// requests do not overlap, sharing the single shared 35x18 multiplier and the one read port.
// Reset: aresetn synchronous active low, clears point count, sequencer and output valid;
// point memory is not cleared (only entries below the count are ever used).
module catmull_rom_point_eval #(
    parameter int MAX_POINTS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // point_x [11:0], point_y [23:12], param_t [40:24]
    input  logic [1:0]  s_tuser,   // operation [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // curve_x [21:0], curve_y [43:22]
    output logic [1:0]  m_tuser    // status [1:0]
);

    `include "catmull_rom_point_eval_assert.svh"

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CW     = crpe_pkg::COORD_W;
    localparam int PW     = crpe_pkg::POINT_W;
    localparam int OW     = crpe_pkg::OUT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_SEG, S_RD_PM1, S_RD_P0, S_RD_P1, S_RD_P2, S_RD_LAST, S_MUL, S_DONE
    } state_t;

    typedef enum logic [2:0] {MS_A, MS_B, MS_H, MS_L, MS_ROUND} mstep_t;

    logic [PW-1:0] mem [MAX_POINTS];
    logic [PW-1:0] rd_q;
    logic [ADDR_W-1:0] rd_addr;
    logic mem_we;

    state_t state_reg, state_next;
    mstep_t step_reg, step_next;
    logic axis_reg, axis_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0] op_reg, op_next;
    logic [PW-1:0] pt_reg, pt_next;
    logic [crpe_pkg::T_W-1:0] t_reg, t_next;
    logic [ADDR_W-1:0] seg_reg, seg_next;
    logic [crpe_pkg::T_W-1:0] w_reg, w_next;
    logic has_prev_reg, has_prev_next, has_next_reg, has_next_next;
    logic [PW-1:0] pm1_reg, pm1_next, p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    logic signed [crpe_pkg::MUL_P_W-1:0] mul_q_reg, mul_q_next;
    logic signed [crpe_pkg::H_W-1:0] h_reg, h_next;
    logic [OW-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic [1:0] res_st_reg, res_st_next;
    logic [OW-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [1:0] out_st_reg, out_st_next;
    logic m_valid_reg, m_valid_next;

    logic signed [crpe_pkg::MUL_A_W-1:0] mul_a;
    logic [crpe_pkg::T_W-1:0] mul_b;
    logic signed [crpe_pkg::MUL_P_W-1:0] mul_p, mul_add, mul_sum;

    logic [CNT_W-1:0] cnt_m1, seg_full, seg_c;
    logic [crpe_pkg::T_W-1:0] t_sat;
    logic [CW-1:0] ax_pm1, ax_p0, ax_p1, ax_p2;
    logic signed [17:0] q_pm1, q_p0, q_p1, q_p2, d, v0, v1, c0, c1, c3;
    logic signed [crpe_pkg::H_W-1:0] rnd_sum;
    logic signed [27:0] rnd_r;
    logic [OW-1:0] rnd_sat;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, out_y_reg, out_x_reg};
    assign m_tuser  = out_st_reg;

    assign cnt_m1   = count_reg - CNT_W'(1);
    assign t_sat    = (t_reg > crpe_pkg::ONE_Q16) ? crpe_pkg::ONE_Q16 : t_reg;
    assign seg_full = mul_q_reg[16 +: CNT_W];

    // shared multiplier: signed operand times unsigned 17-bit weight, plus addend
    assign mul_p   = mul_a * $signed({1'b0, mul_b});
    assign mul_sum = mul_p + mul_add;

    // per-axis Hermite coefficients, tangents kept doubled
    assign ax_pm1 = axis_reg ? pm1_reg[PW-1:CW] : pm1_reg[CW-1:0];
    assign ax_p0  = axis_reg ? p0_reg[PW-1:CW]  : p0_reg[CW-1:0];
    assign ax_p1  = axis_reg ? p1_reg[PW-1:CW]  : p1_reg[CW-1:0];
    assign ax_p2  = axis_reg ? p2_reg[PW-1:CW]  : p2_reg[CW-1:0];
    assign q_pm1  = $signed({6'b0, ax_pm1});
    assign q_p0   = $signed({6'b0, ax_p0});
    assign q_p1   = $signed({6'b0, ax_p1});
    assign q_p2   = $signed({6'b0, ax_p2});
    assign d      = q_p1 - q_p0;
    assign v0     = has_prev_reg ? (q_p1 - q_pm1) : (d <<< 1);
    assign v1     = has_next_reg ? (q_p2 - q_p0) : (d <<< 1);
    assign c0     = v0 + v1 - (d <<< 2);
    assign c1     = (d <<< 2) + (d <<< 1) - (v0 <<< 1) - v1;
    assign c3     = q_p0 <<< 1;

    assign rnd_sum = h_reg + $signed({27'b0, mul_q_reg[41:25]});
    assign rnd_r   = rnd_sum[43:16];
    assign rnd_sat = (rnd_r[27:21] == 7'h00 || rnd_r[27:21] == 7'h7F) ? rnd_r[OW-1:0]
                   : (rnd_r[27] ? crpe_pkg::OUT_MIN : crpe_pkg::OUT_MAX);

    always_comb begin
        mul_a = '0;
        mul_b = w_reg;
        mul_add = '0;
        if (state_reg == S_EXEC) begin
            mul_a = $signed(crpe_pkg::MUL_A_W'(cnt_m1));
            mul_b = t_sat;
        end else begin
            case (step_reg)
                MS_A: begin
                    mul_a = crpe_pkg::MUL_A_W'(c0);
                    mul_add = crpe_pkg::MUL_P_W'(c1) <<< 16;
                end
                MS_B: begin
                    mul_a = $signed(mul_q_reg[crpe_pkg::MUL_A_W-1:0]);
                    mul_add = crpe_pkg::MUL_P_W'(v0) <<< 32;
                end
                MS_H: begin
                    mul_a = crpe_pkg::MUL_A_W'($signed(mul_q_reg[52:25]));
                    mul_add = crpe_pkg::MUL_P_W'(c3) <<< 23;
                end
                MS_L: begin
                    mul_a = $signed({10'b0, mul_q_reg[24:0]});
                    mul_add = $signed(crpe_pkg::ROUND_HALF);
                end
                default: begin
                    mul_a = '0;
                end
            endcase
        end
    end

    always_comb begin
        if (seg_full >= cnt_m1) begin
            seg_c = count_reg - CNT_W'(2);
        end else begin
            seg_c = seg_full;
        end
    end

    always_comb begin
        case (state_reg)
            S_RD_PM1: rd_addr = has_prev_reg ? seg_reg - ADDR_W'(1) : seg_reg;
            S_RD_P1:  rd_addr = seg_reg + ADDR_W'(1);
            S_RD_P2:  rd_addr = has_next_reg ? seg_reg + ADDR_W'(2) : seg_reg;
            default:  rd_addr = seg_reg;
        endcase
    end

    assign mem_we = (state_reg == S_EXEC) && (op_reg == crpe_pkg::OP_APPEND)
                 && (count_reg != CNT_W'(MAX_POINTS));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[ADDR_W-1:0]] <= pt_reg;
        end
        rd_q <= mem[rd_addr];
    end

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        axis_next     = axis_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        pt_next       = pt_reg;
        t_next        = t_reg;
        seg_next      = seg_reg;
        w_next        = w_reg;
        has_prev_next = has_prev_reg;
        has_next_next = has_next_reg;
        pm1_next      = pm1_reg;
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        mul_q_next    = mul_q_reg;
        h_next        = h_reg;
        res_x_next    = res_x_reg;
        res_y_next    = res_y_reg;
        res_st_next   = res_st_reg;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_st_next   = out_st_reg;
        m_valid_next  = m_valid_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    pt_next    = s_tdata[PW-1:0];
                    t_next     = s_tdata[40:24];
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_x_next  = '0;
                res_y_next  = '0;
                res_st_next = crpe_pkg::ST_OK;
                state_next  = S_DONE;
                case (op_reg)
                    crpe_pkg::OP_CLEAR: begin
                        count_next = '0;
                    end
                    crpe_pkg::OP_APPEND: begin
                        if (count_reg == CNT_W'(MAX_POINTS)) begin
                            res_st_next = crpe_pkg::ST_FULL;
                        end else begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    crpe_pkg::OP_EVAL: begin
                        if (count_reg < CNT_W'(2)) begin
                            res_st_next = crpe_pkg::ST_TOO_FEW;
                        end else begin
                            mul_q_next = mul_sum;
                            state_next = S_SEG;
                        end
                    end
                    default: begin
                        res_st_next = crpe_pkg::ST_OK;
                    end
                endcase
            end
            S_SEG: begin
                seg_next      = seg_c[ADDR_W-1:0];
                w_next        = (seg_full >= cnt_m1) ? crpe_pkg::ONE_Q16
                                                     : {1'b0, mul_q_reg[15:0]};
                has_prev_next = (seg_c != '0);
                has_next_next = ((CNT_W+1)'(seg_c) + (CNT_W+1)'(2)) < (CNT_W+1)'(count_reg);
                state_next    = S_RD_PM1;
            end
            S_RD_PM1: state_next = S_RD_P0;
            S_RD_P0: begin
                pm1_next   = rd_q;
                state_next = S_RD_P1;
            end
            S_RD_P1: begin
                p0_next    = rd_q;
                state_next = S_RD_P2;
            end
            S_RD_P2: begin
                p1_next    = rd_q;
                state_next = S_RD_LAST;
            end
            S_RD_LAST: begin
                p2_next    = rd_q;
                step_next  = MS_A;
                axis_next  = 1'b0;
                state_next = S_MUL;
            end
            S_MUL: begin
                case (step_reg)
                    MS_A: begin
                        mul_q_next = mul_sum;
                        step_next  = MS_B;
                    end
                    MS_B: begin
                        mul_q_next = mul_sum;
                        step_next  = MS_H;
                    end
                    MS_H: begin
                        h_next    = mul_sum[crpe_pkg::H_W-1:0];
                        step_next = MS_L;
                    end
                    MS_L: begin
                        mul_q_next = mul_sum;
                        step_next  = MS_ROUND;
                    end
                    default: begin
                        step_next = MS_A;
                        if (axis_reg) begin
                            res_y_next = rnd_sat;
                            state_next = S_DONE;
                        end else begin
                            res_x_next = rnd_sat;
                            axis_next  = 1'b1;
                        end
                    end
                endcase
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    out_x_next   = res_x_reg;
                    out_y_next   = res_y_reg;
                    out_st_next  = res_st_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            step_reg    <= MS_A;
            axis_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            step_reg    <= step_next;
            axis_reg    <= axis_next;
        end
        op_reg       <= op_next;
        pt_reg       <= pt_next;
        t_reg        <= t_next;
        seg_reg      <= seg_next;
        w_reg        <= w_next;
        has_prev_reg <= has_prev_next;
        has_next_reg <= has_next_next;
        pm1_reg      <= pm1_next;
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        mul_q_reg    <= mul_q_next;
        h_reg        <= h_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_st_reg   <= res_st_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_st_reg   <= out_st_next;
    end

    `CRPE_ASSERT_IMP(a_count_max, 1'b1, count_reg <= CNT_W'(MAX_POINTS))
    `CRPE_ASSERT_NXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)
    `CRPE_ASSERT_IMP(a_err_zero, m_tvalid && m_tuser != crpe_pkg::ST_OK, m_tdata == '0)
    `CRPE_ASSERT_IMP(a_seg_range, state_reg == S_MUL,
        ((CNT_W+1)'(seg_reg) + (CNT_W+1)'(2)) <= (CNT_W+1)'(count_reg))
    `CRPE_ASSERT_NXT(a_count_hold, state_reg != S_EXEC, $stable(count_reg))

endmodule
